@@ src/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/ngp_pkg.sv @@
`timescale 1ns / 1ps

package ngp_pkg;

    localparam int NUM_SIZES = 5;
    localparam int SLOTS     = 64;
    localparam int NCELL     = SLOTS - 1;
    localparam int POS_W     = (NCELL > 1) ? $clog2(NCELL) : 1;
    localparam int SIZE_W    = 3;
    localparam int SLOT_W    = 6;
    localparam int KEY_W     = 64;
    localparam int CNT_W     = 32;
    localparam int TICK_W    = 32;

    localparam logic [7:0]       SPACE_BYTE   = 8'h20;
    localparam logic [7:0]       NEWLINE_BYTE = 8'h0A;
    localparam logic [KEY_W-1:0] ALL_SPACES   = 64'h2020_2020_2020_2020;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;

    localparam logic [1:0] FN_FEED  = 2'd0;
    localparam logic [1:0] FN_READ  = 2'd1;
    localparam logic [1:0] FN_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CMP,
        ST_CHK,
        ST_EVICT,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [1:0]        func;
        logic [7:0]        text_byte;
        logic [SIZE_W-1:0] size_sel;
        logic [SLOT_W-1:0] slot_sel;
    } t_cmd;

    typedef struct packed {
        logic             entry_valid;
        logic [KEY_W-1:0] entry_gram;
        logic [CNT_W-1:0] entry_count;
        logic [CNT_W-1:0] rest_count;
        logic [CNT_W-1:0] total_count;
    } t_res;

    typedef struct packed {
        logic              used;
        logic [KEY_W-1:0]  key;
        logic [CNT_W-1:0]  count;
        logic [TICK_W-1:0] stamp;
    } t_slot;

    typedef struct packed {
        logic              start_feed;
        logic              clr_start;
        logic              mul;
        logic              cmp;
        logic              evict;
        logic              clr_step;
        logic [POS_W-1:0]  pos;
        logic [TICK_W-1:0] tick;
    } t_tctl;

endpackage

@@ src/ngp_cell.sv @@
`timescale 1ns / 1ps

module ngp_cell (
    input  logic          i_clk,
    input  logic          i_shift,
    input  ngp_pkg::t_slot i_d,
    output ngp_pkg::t_slot o_q
);

    ngp_pkg::t_slot r_q;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

@@ src/ngp_table.sv @@
`timescale 1ns / 1ps

module ngp_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ngp_pkg::t_tctl                i_ctl,
    input  logic [ngp_pkg::KEY_W-1:0]     i_key,
    input  logic                          i_active,
    input  logic [ngp_pkg::POS_W-1:0]     i_rd_pos,
    output ngp_pkg::t_slot                o_rd,
    output logic [ngp_pkg::CNT_W-1:0]     o_rest,
    output logic [ngp_pkg::CNT_W-1:0]     o_total,
    output logic                          o_need
);

    ngp_pkg::t_slot w_q [ngp_pkg::NCELL];
    ngp_pkg::t_slot w_d [ngp_pkg::NCELL];
    ngp_pkg::t_slot w_head;
    ngp_pkg::t_slot w_out;
    ngp_pkg::t_slot w_new;
    logic           w_shift;
    logic           w_open;
    logic           w_hit;
    logic           w_take;
    logic           w_evict_hit;
    logic [ngp_pkg::TICK_W-1:0] w_age_v;
    logic [ngp_pkg::TICK_W-1:0] w_age_h;

    logic                          r_active;
    logic                          r_found;
    logic                          r_hv;
    logic [ngp_pkg::POS_W-1:0]     r_vpos;
    logic [ngp_pkg::CNT_W-1:0]     r_vcnt;
    logic [ngp_pkg::TICK_W-1:0]    r_vstamp;
    logic [2*ngp_pkg::CNT_W-1:0]   r_lhs;
    logic [2*ngp_pkg::CNT_W-1:0]   r_rhs;
    logic [ngp_pkg::CNT_W-1:0]     r_rest;
    logic [ngp_pkg::CNT_W-1:0]     r_total;

    assign w_shift = i_ctl.cmp | i_ctl.evict | i_ctl.clr_step;

    genvar g;
    generate
        for (g = 0; g < ngp_pkg::NCELL; g++) begin : g_cell
            ngp_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_d     (w_d[g]),
                .o_q     (w_q[g])
            );
            if (g == ngp_pkg::NCELL - 1) begin : g_tail
                assign w_d[g] = w_out;
            end else begin : g_link
                assign w_d[g] = w_q[g+1];
            end
        end
    endgenerate

    assign w_head  = w_q[0];
    assign w_open  = r_active && !r_found;
    assign w_hit   = w_head.used && (w_head.key == i_key);
    assign w_take  = !r_hv || (r_lhs < r_rhs);
    assign w_age_v = i_ctl.tick - r_vstamp;
    assign w_age_h = i_ctl.tick - w_head.stamp;
    assign w_evict_hit = i_ctl.evict && w_open && (i_ctl.pos == r_vpos);

    always_comb begin
        w_new.used  = 1'b1;
        w_new.key   = i_key;
        w_new.count = ngp_pkg::CNT_W'(1);
        w_new.stamp = i_ctl.tick;
    end

    // Modify the slot at the head as it rotates past.
    always_comb begin
        w_out = w_head;
        priority if (i_ctl.clr_step) begin
            w_out.used = 1'b0;
        end else if (i_ctl.cmp && w_open && !w_head.used) begin
            w_out = w_new;
        end else if (i_ctl.cmp && w_open && w_hit) begin
            w_out.count = (w_head.count == ngp_pkg::CNT_MAX) ? w_head.count
                                                              : w_head.count + 1'b1;
            w_out.stamp = i_ctl.tick;
        end else if (w_evict_hit) begin
            w_out = w_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_found  <= 1'b0;
            r_hv     <= 1'b0;
            r_rest   <= '0;
            r_total  <= '0;
        end else begin
            if (i_ctl.clr_start) begin
                r_rest   <= '0;
                r_total  <= '0;
                r_active <= 1'b0;
            end else if (i_ctl.start_feed) begin
                r_active <= i_active;
                r_found  <= 1'b0;
                r_hv     <= 1'b0;
                if (i_active && r_total != ngp_pkg::CNT_MAX) begin
                    r_total <= r_total + 1'b1;
                end
            end else if (i_ctl.cmp && w_open) begin
                if (!w_head.used || w_hit) begin
                    r_found <= 1'b1;
                end else if (w_take) begin
                    r_hv <= 1'b1;
                end
            end else if (w_evict_hit) begin
                // saturate the rest sum
                r_rest <= (r_rest + w_head.count < r_rest) ? ngp_pkg::CNT_MAX
                                                          : r_rest + w_head.count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_lhs <= (2*ngp_pkg::CNT_W)'(w_head.count) * (2*ngp_pkg::CNT_W)'(w_age_v);
            r_rhs <= (2*ngp_pkg::CNT_W)'(r_vcnt) * (2*ngp_pkg::CNT_W)'(w_age_h);
        end
        if (i_ctl.cmp && w_open && w_head.used && !w_hit && w_take) begin
            r_vpos   <= i_ctl.pos;
            r_vcnt   <= w_head.count;
            r_vstamp <= w_head.stamp;
        end
    end

    always_comb begin
        o_rd = w_q[0];
        for (int k = 0; k < ngp_pkg::NCELL; k++) begin
            if (i_rd_pos == ngp_pkg::POS_W'(k)) begin
                o_rd = w_q[k];
            end
        end
    end

    assign o_rest  = r_rest;
    assign o_total = r_total;
    assign o_need  = w_open;

endmodule

@@ src/ngram_frequency_profiler.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Byte-stream n-gram profiler with one rotating table per n-gram size. A command
// is taken when i_start is high and o_busy is low; its result appears on o_res for
// one cycle with o_done, and must be captured then since it cannot be stalled.
// A read, a newline byte or an unused code answers on the next cycle. Any other byte
// holds o_busy while each table rotates its slot cells past one shared compare unit,
// which spends a multiply step and a compare step on each slot, then checks the tables
// and answers in the cycle after; when a full table must replace an entry, a second
// rotation follows before the answer. Clear, and the clearing pass after reset, sweep
// the tables once with o_busy high.
module ngram_frequency_profiler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  ngp_pkg::t_cmd i_cmd,
    output logic          o_busy,
    output logic          o_done,
    output ngp_pkg::t_res o_res
);

    localparam logic [ngp_pkg::POS_W-1:0] LAST_POS = ngp_pkg::POS_W'(ngp_pkg::NCELL - 1);

    function automatic logic [ngp_pkg::KEY_W-1:0] gram_mask(input int idx);
        logic [ngp_pkg::KEY_W-1:0] m;
        m = '1;
        if (idx < 7) begin
            m = (64'd1 << (8 * (idx + 1))) - 64'd1;
        end
        return m;
    endfunction

    ngp_pkg::t_state              r_state;
    ngp_pkg::t_state              n_state;
    logic [ngp_pkg::POS_W-1:0]    r_pos;
    logic [ngp_pkg::POS_W-1:0]    n_pos;
    logic [ngp_pkg::KEY_W-1:0]    r_hist;
    logic [ngp_pkg::KEY_W-1:0]    n_hist_feed;
    logic [ngp_pkg::TICK_W-1:0]   r_tick;
    logic                         r_clr_res;
    logic                         r_done;
    logic                         n_done;
    ngp_pkg::t_res                r_res;
    ngp_pkg::t_res                n_res;
    ngp_pkg::t_res                w_read;
    ngp_pkg::t_tctl               w_ctl;
    logic                         w_acc;
    logic                         w_is_nl;
    logic                         w_feed_end;
    logic                         w_clr_end;
    logic                         w_slot_ok;
    logic [ngp_pkg::SLOT_W-1:0]   w_slot_m1;
    logic [ngp_pkg::POS_W-1:0]    w_rd_pos;
    logic [ngp_pkg::NUM_SIZES-1:0] w_need;
    ngp_pkg::t_slot               w_rd    [ngp_pkg::NUM_SIZES];
    logic [ngp_pkg::CNT_W-1:0]    w_rest  [ngp_pkg::NUM_SIZES];
    logic [ngp_pkg::CNT_W-1:0]    w_total [ngp_pkg::NUM_SIZES];

    assign o_busy      = (r_state != ngp_pkg::ST_IDLE);
    assign w_acc       = i_start && !o_busy;
    assign w_is_nl     = (i_cmd.text_byte == ngp_pkg::NEWLINE_BYTE);
    assign n_hist_feed = {r_hist[ngp_pkg::KEY_W-9:0], i_cmd.text_byte};
    assign w_slot_m1   = i_cmd.slot_sel - 1'b1;
    assign w_rd_pos    = ngp_pkg::POS_W'(w_slot_m1);
    assign w_slot_ok   = (i_cmd.slot_sel != '0) && (32'(i_cmd.slot_sel) < 32'(ngp_pkg::SLOTS));

    genvar g;
    generate
        for (g = 0; g < ngp_pkg::NUM_SIZES; g++) begin : g_tab
            ngp_table u_table (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_key    (r_hist & gram_mask(g)),
                .i_active (n_hist_feed[8*g +: 8] != ngp_pkg::SPACE_BYTE),
                .i_rd_pos (w_rd_pos),
                .o_rd     (w_rd[g]),
                .o_rest   (w_rest[g]),
                .o_total  (w_total[g]),
                .o_need   (w_need[g])
            );
        end
    endgenerate

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ngp_pkg::ST_IDLE: begin
                if (w_acc && i_cmd.func == ngp_pkg::FN_FEED && !w_is_nl) begin
                    n_state = ngp_pkg::ST_MUL;
                end else if (w_acc && i_cmd.func == ngp_pkg::FN_CLEAR) begin
                    n_state = ngp_pkg::ST_CLEAR;
                end
            end
            ngp_pkg::ST_MUL:   n_state = ngp_pkg::ST_CMP;
            ngp_pkg::ST_CMP:   n_state = (r_pos == LAST_POS) ? ngp_pkg::ST_CHK : ngp_pkg::ST_MUL;
            ngp_pkg::ST_CHK:   n_state = (|w_need) ? ngp_pkg::ST_EVICT : ngp_pkg::ST_IDLE;
            ngp_pkg::ST_EVICT: n_state = (r_pos == LAST_POS) ? ngp_pkg::ST_IDLE : ngp_pkg::ST_EVICT;
            ngp_pkg::ST_CLEAR: n_state = (r_pos == LAST_POS) ? ngp_pkg::ST_IDLE : ngp_pkg::ST_CLEAR;
            default:           n_state = ngp_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        w_ctl      = '0;
        w_ctl.pos  = r_pos;
        w_ctl.tick = r_tick;
        n_pos      = r_pos;
        w_feed_end = 1'b0;
        w_clr_end  = 1'b0;
        unique case (r_state)
            ngp_pkg::ST_IDLE: begin
                w_ctl.start_feed = w_acc && (i_cmd.func == ngp_pkg::FN_FEED) && !w_is_nl;
                w_ctl.clr_start  = w_acc && (i_cmd.func == ngp_pkg::FN_CLEAR);
            end
            ngp_pkg::ST_MUL: begin
                w_ctl.mul = 1'b1;
            end
            ngp_pkg::ST_CMP: begin
                w_ctl.cmp = 1'b1;
                n_pos     = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
            end
            ngp_pkg::ST_CHK: begin
                w_feed_end = !(|w_need);
            end
            ngp_pkg::ST_EVICT: begin
                w_ctl.evict = 1'b1;
                n_pos       = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                w_feed_end  = (r_pos == LAST_POS);
            end
            ngp_pkg::ST_CLEAR: begin
                w_ctl.clr_step = 1'b1;
                n_pos          = (r_pos == LAST_POS) ? '0 : r_pos + 1'b1;
                w_clr_end      = (r_pos == LAST_POS);
            end
            default: ;
        endcase
    end

    always_comb begin
        w_read = '0;
        for (int k = 0; k < ngp_pkg::NUM_SIZES; k++) begin
            if (i_cmd.size_sel == ngp_pkg::SIZE_W'(k)) begin
                w_read.rest_count  = w_rest[k];
                w_read.total_count = w_total[k];
                if (w_slot_ok && w_rd[k].used) begin
                    w_read.entry_valid = 1'b1;
                    w_read.entry_gram  = w_rd[k].key;
                    w_read.entry_count = w_rd[k].count;
                end
            end
        end
    end

    always_comb begin
        n_done = w_feed_end || (w_clr_end && r_clr_res)
              || (w_acc && !w_ctl.start_feed && !w_ctl.clr_start);
        n_res  = '0;
        if (w_acc && i_cmd.func == ngp_pkg::FN_READ) begin
            n_res = w_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ngp_pkg::ST_CLEAR;
            r_pos     <= '0;
            r_hist    <= ngp_pkg::ALL_SPACES;
            r_tick    <= '0;
            r_clr_res <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_done  <= n_done;
            if (w_ctl.clr_start) begin
                r_hist    <= ngp_pkg::ALL_SPACES;
                r_tick    <= '0;
                r_clr_res <= 1'b1;
            end else if (w_acc && i_cmd.func == ngp_pkg::FN_FEED) begin
                r_hist <= w_is_nl ? ngp_pkg::ALL_SPACES : n_hist_feed;
                if (w_is_nl) begin
                    r_tick <= r_tick + 1'b1;
                end
            end else if (w_feed_end) begin
                r_tick <= r_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

    `ASSERT_NEXT(a_read_done, w_acc && (i_cmd.func == ngp_pkg::FN_READ), o_done, "read transfer gave no result")
    `ASSERT_NEXT(a_nl_done, w_acc && (i_cmd.func == ngp_pkg::FN_FEED) && w_is_nl, o_done && !o_busy, "newline transfer not finished")
    `ASSERT_IMPL(a_evict_need, r_state == ngp_pkg::ST_EVICT, |w_need, "eviction pass without a pending table")

endmodule

@@ tb/ngram_frequency_profiler_checker.sv @@
`timescale 1ns / 1ps

module ngram_frequency_profiler_checker
    import ngp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    input  logic i_busy,
    input  logic i_done,
    input  t_res i_res,
    output int   o_fail_cnt,
    output int   o_pending
);

    localparam int NTAB = NUM_SIZES * SLOTS;

    logic [KEY_W-1:0]  hist;
    logic [KEY_W-1:0]  keys  [NTAB];
    logic [CNT_W-1:0]  cnts  [NTAB];
    logic [TICK_W-1:0] stamps[NTAB];
    logic              used  [NTAB];
    logic [CNT_W-1:0]  evict_sum[NUM_SIZES];
    logic [CNT_W-1:0]  seen_cnt [NUM_SIZES];
    logic [TICK_W-1:0] tick;

    t_res expected_res[$];

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

    task automatic clear_profile();
        hist = ALL_SPACES;
        tick = '0;
        for (int i = 0; i < NTAB; i++) begin
            used[i] = 1'b0;
            cnts[i] = '0;
            keys[i] = '0;
            stamps[i] = '0;
        end
        for (int s = 0; s < NUM_SIZES; s++) begin
            evict_sum[s] = '0;
            seen_cnt[s] = '0;
        end
    endtask

    task automatic tally_gram(int s, logic [KEY_W-1:0] key);
        int  base;
        int  victim;
        bit  have_victim;
        logic [63:0] lhs, rhs;
        base = s * SLOTS;
        victim = 0;
        have_victim = 0;
        for (int j = 1; j < SLOTS; j++) begin
            if (!used[base + j]) begin
                used[base + j] = 1'b1;
                keys[base + j] = key;
                cnts[base + j] = 1;
                stamps[base + j] = tick;
                return;
            end
            if (keys[base + j] == key) begin
                cnts[base + j] = sat_inc(cnts[base + j], 1);
                stamps[base + j] = tick;
                return;
            end
            if (!have_victim) begin
                victim = base + j;
                have_victim = 1;
            end else begin
                lhs = 64'(cnts[base + j]) * 64'(tick - stamps[victim]);
                rhs = 64'(cnts[victim]) * 64'(tick - stamps[base + j]);
                if (lhs < rhs) victim = base + j;
            end
        end
        if (have_victim) begin
            evict_sum[s] = sat_inc(evict_sum[s], cnts[victim]);
            keys[victim] = key;
            cnts[victim] = 1;
            stamps[victim] = tick;
        end
    endtask

    task automatic profile_cmd(t_cmd c, output t_res r);
        int ix;
        logic [KEY_W-1:0] mask;
        r = '0;
        case (c.func)
            FN_FEED: begin
                if (c.text_byte == NEWLINE_BYTE) begin
                    hist = ALL_SPACES;
                end else begin
                    hist = {hist[KEY_W-9:0], c.text_byte};
                    for (int s = 0; s < NUM_SIZES; s++) begin
                        if (hist[8*s +: 8] != SPACE_BYTE) begin
                            mask = (s + 1 >= 8) ? '1 : ((64'd1 << (8 * (s + 1))) - 1);
                            tally_gram(s, hist & mask);
                            seen_cnt[s] = sat_inc(seen_cnt[s], 1);
                        end
                    end
                end
                tick = tick + 1;
            end
            FN_CLEAR: clear_profile();
            FN_READ: begin
                if (c.size_sel < NUM_SIZES) begin
                    r.rest_count = evict_sum[c.size_sel];
                    r.total_count = seen_cnt[c.size_sel];
                    if (c.slot_sel >= 1 && c.slot_sel < SLOTS) begin
                        ix = c.size_sel * SLOTS + c.slot_sel;
                        if (used[ix]) begin
                            r.entry_valid = 1'b1;
                            r.entry_gram = keys[ix];
                            r.entry_count = cnts[ix];
                        end
                    end
                end
            end
            default: ;
        endcase
    endtask

    initial clear_profile();

    assign o_pending = expected_res.size();

    always @(posedge i_clk) begin
        t_res r, want;
        if (!i_rst_n) begin
            o_fail_cnt <= 0;
        end else begin
            // compare first: a result can never come in the same cycle as its command
            if (i_done) begin
                if (expected_res.size() == 0) begin
                    if (o_fail_cnt < 10) $display("unexpected result %h", i_res);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = expected_res.pop_front();
                    if (i_res !== want) begin
                        if (o_fail_cnt < 10)
                            $display("mismatch: exp v=%b g=%h c=%h r=%h t=%h got v=%b g=%h c=%h r=%h t=%h",
                                     want.entry_valid, want.entry_gram, want.entry_count,
                                     want.rest_count, want.total_count,
                                     i_res.entry_valid, i_res.entry_gram, i_res.entry_count,
                                     i_res.rest_count, i_res.total_count);
                        o_fail_cnt <= o_fail_cnt + 1;
                    end
                end
            end
            if (i_start && !i_busy) begin
                profile_cmd(i_cmd, r);
                expected_res.push_back(r);
            end
        end
    end

endmodule

@@ tb/ngram_frequency_profiler_tb.sv @@
`timescale 1ns / 1ps

module ngram_frequency_profiler_tb;
    import ngp_pkg::*;

    localparam longint CYCLE_LIMIT = 1500000;
    localparam logic [1:0] FN_SPARE = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    t_cmd i_cmd = '0;
    logic o_busy, o_done;
    t_res o_res;
    int   fail_cnt, pending;
    int   idle_pct;
    longint cycles = 0;

    always #5 i_clk = ~i_clk;

    ngram_frequency_profiler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .o_busy(o_busy), .o_done(o_done), .o_res(o_res)
    );

    ngram_frequency_profiler_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_cmd(i_cmd),
        .i_busy(o_busy), .i_done(o_done), .i_res(o_res),
        .o_fail_cnt(fail_cnt), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold start until the block takes the transfer; drop it only for idle gaps.
    task automatic issue_cmd(t_cmd c);
        if ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        end
        i_cmd <= c;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    function automatic t_cmd mk(logic [1:0] f, logic [7:0] b, logic [2:0] sz, logic [5:0] sl);
        t_cmd c;
        c.func = f;
        c.text_byte = b;
        c.size_sel = sz;
        c.slot_sel = sl;
        return c;
    endfunction

    task automatic feed_word();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++)
            issue_cmd(mk(FN_FEED, 8'h61 + 8'($urandom_range(0, 5)), 3'($urandom), 6'($urandom)));
        issue_cmd(mk(FN_FEED, ($urandom_range(3) == 0) ? NEWLINE_BYTE : SPACE_BYTE,
                     3'($urandom), 6'($urandom)));
    endtask

    task automatic random_cmd();
        int p;
        p = $urandom_range(99);
        if (p < 45) feed_word();
        else if (p < 60) issue_cmd(mk(FN_FEED, 8'($urandom), 3'($urandom), 6'($urandom)));
        else if (p < 93) issue_cmd(mk(FN_READ, 8'($urandom), 3'($urandom_range(0, 5)),
                                      6'($urandom)));
        else if (p < 97) issue_cmd(mk(FN_SPARE, 8'($urandom), 3'($urandom), 6'($urandom)));
        else issue_cmd(mk(FN_CLEAR, 8'($urandom), 3'($urandom), 6'($urandom)));
    endtask

    initial begin
        idle_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, byte zero, newline, every code, out-of-range reads
        issue_cmd(mk(FN_FEED, 8'h00, 3'd7, 6'd63));
        issue_cmd(mk(FN_FEED, 8'hFF, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, 8'h00, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, 8'hFF, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, 8'hFF, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, NEWLINE_BYTE, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, 8'h55, 3'd0, 6'd0));
        issue_cmd(mk(FN_FEED, 8'hAA, 3'd0, 6'd0));
        for (int s = 0; s < 8; s++) issue_cmd(mk(FN_READ, 8'hFF, 3'(s), 6'd1));
        issue_cmd(mk(FN_READ, 8'h00, 3'd0, 6'd0));
        issue_cmd(mk(FN_READ, 8'h00, 3'd0, 6'd63));
        issue_cmd(mk(FN_READ, 8'h00, 3'd1, 6'd2));
        issue_cmd(mk(FN_SPARE, 8'hFF, 3'd7, 6'd63));
        issue_cmd(mk(FN_CLEAR, 8'h00, 3'd0, 6'd0));
        issue_cmd(mk(FN_READ, 8'h00, 3'd0, 6'd1));

        // fill every size past capacity to force replacements
        for (int k = 0; k < 80; k++) issue_cmd(mk(FN_FEED, 8'(k + 100), 3'd0, 6'd0));
        for (int k = 0; k < 6; k++) issue_cmd(mk(FN_READ, 8'd0, 3'(k), 6'($urandom)));

        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 50 : (ph == 3) ? 10 : 0;
            repeat (42) random_cmd();
        end
        idle_pct = 0;
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/ngp_pkg.sv
src/ngp_cell.sv
src/ngp_table.sv
src/ngram_frequency_profiler.sv
tb/ngram_frequency_profiler_checker.sv
tb/ngram_frequency_profiler_tb.sv
